// File: hdl/swt_pkg.sv
`timescale 1ns / 1ps

package swt_pkg;

    // character codes the tokenizer reacts to
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // token kinds
    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_PUNCT  = 2'd2;
    localparam logic [1:0] KIND_STRING = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_END     = 2'd1;
    localparam logic [1:0] ERR_COMMENT = 2'd2;
    localparam logic [1:0] ERR_STRING  = 2'd3;

    // open token mode
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // register index of the configuration port
    localparam logic REG_END_IS_ERROR = 1'b0;

    typedef enum logic [3:0] {
        PH_PLAIN       = 4'd0,
        PH_SLASH       = 4'd1,
        PH_COMMENT     = 4'd2,
        PH_COMMENT_STAR = 4'd3,
        PH_QUOTE       = 4'd4,
        PH_STRING      = 4'd5,
        PH_ESCAPED     = 4'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] token_char;
        logic       char_valid;
        logic       token_last;
        logic [1:0] token_kind;
        logic [1:0] error_code;
    } res_t;

    typedef struct packed {
        logic [1:0] res_n;
        res_t       res0;
        res_t       res1;
        phase_t     phase_next;
        logic [1:0] mode_next;
        logic [7:0] held_next;
    } step_t;

endpackage

// File: hdl/swt_step.sv
`timescale 1ns / 1ps

module swt_step (
    input  logic [7:0]      byte_in,
    input  logic            end_of_input,
    input  logic            end_is_error,
    input  swt_pkg::phase_t phase,
    input  logic [1:0]      mode,
    input  logic [7:0]      held,
    output swt_pkg::step_t  step
);
    import swt_pkg::*;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    function automatic res_t mk(input logic [7:0] ch, input logic valid, input logic last,
                                input logic [1:0] kind, input logic [1:0] err);
        res_t r;
        r.token_char = ch;
        r.char_valid = valid;
        r.token_last = last;
        r.token_kind = kind;
        r.error_code = err;
        return r;
    endfunction

    res_t       res [2];
    logic [1:0] cnt;
    phase_t     ph;
    logic [1:0] m;
    logic [7:0] hc;
    logic       do_plain;

    always_comb
    begin
        res[0]   = '0;
        res[1]   = '0;
        cnt      = 2'd0;
        ph       = (phase > PH_ESCAPED) ? PH_PLAIN : phase;
        m        = (mode > MODE_NUMBER) ? MODE_NONE : mode;
        hc       = held;
        do_plain = 1'b0;

        if (end_of_input)
        begin
            if (ph == PH_PLAIN || ph == PH_SLASH)
            begin
                // pending slash is settled first
                if (ph == PH_SLASH)
                begin
                    if (m != MODE_NONE)
                    begin
                        res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, m - 2'd1, ERR_NONE);
                        cnt = cnt + 2'd1;
                        m = MODE_NONE;
                    end
                    else
                    begin
                        res[cnt[0]] = mk(CH_SLASH, 1'b1, 1'b1, KIND_PUNCT, ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                end
                if (end_is_error)
                begin
                    res[cnt[0]] = mk(8'd0, 1'b0, 1'b0, KIND_WORD, ERR_END);
                    cnt = cnt + 2'd1;
                end
                else if (m != MODE_NONE)
                begin
                    res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, m - 2'd1, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
            end
            else if (ph == PH_COMMENT || ph == PH_COMMENT_STAR)
            begin
                res[cnt[0]] = mk(8'd0, 1'b0, 1'b0, KIND_WORD, ERR_COMMENT);
                cnt = cnt + 2'd1;
            end
            else
            begin
                res[cnt[0]] = mk(8'd0, 1'b0, 1'b0, KIND_WORD, ERR_STRING);
                cnt = cnt + 2'd1;
            end
            ph = PH_PLAIN;
            m  = MODE_NONE;
            hc = 8'd0;
        end
        else
        begin
            case (ph)
                PH_PLAIN:
                begin
                    do_plain = 1'b1;
                end
                PH_SLASH:
                begin
                    if (byte_in == CH_STAR)
                    begin
                        ph = PH_COMMENT_STAR;
                    end
                    else
                    begin
                        // lone slash: ends an open token, else stands alone
                        if (m != MODE_NONE)
                        begin
                            res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, m - 2'd1, ERR_NONE);
                            cnt = cnt + 2'd1;
                            m = MODE_NONE;
                        end
                        else
                        begin
                            res[cnt[0]] = mk(CH_SLASH, 1'b1, 1'b1, KIND_PUNCT, ERR_NONE);
                            cnt = cnt + 2'd1;
                        end
                        ph = PH_PLAIN;
                        do_plain = 1'b1;
                    end
                end
                PH_COMMENT:
                begin
                    if (byte_in == CH_STAR)
                    begin
                        ph = PH_COMMENT_STAR;
                    end
                end
                PH_COMMENT_STAR:
                begin
                    if (byte_in == CH_SLASH)
                    begin
                        ph = PH_PLAIN;
                        // a comment ends a number, a word goes on
                        if (m == MODE_NUMBER)
                        begin
                            res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, KIND_NUMBER, ERR_NONE);
                            cnt = cnt + 2'd1;
                            m = MODE_NONE;
                        end
                    end
                    else if (byte_in != CH_STAR)
                    begin
                        ph = PH_COMMENT;
                    end
                end
                PH_STRING:
                begin
                    if (byte_in == CH_QUOTE)
                    begin
                        if (hc == CH_BSLASH)
                        begin
                            res[cnt[0]] = mk(CH_QUOTE, 1'b1, 1'b0, KIND_STRING, ERR_NONE);
                            cnt = cnt + 2'd1;
                            ph = PH_ESCAPED;
                        end
                        else
                        begin
                            res[cnt[0]] = mk(hc, 1'b1, 1'b1, KIND_STRING, ERR_NONE);
                            cnt = cnt + 2'd1;
                            ph = PH_PLAIN;
                        end
                        hc = 8'd0;
                    end
                    else
                    begin
                        res[cnt[0]] = mk(hc, 1'b1, 1'b0, KIND_STRING, ERR_NONE);
                        cnt = cnt + 2'd1;
                        hc = byte_in;
                    end
                end
                default:
                begin
                    // just after an opening quote or an escaped quote
                    if (byte_in == CH_QUOTE)
                    begin
                        res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, KIND_STRING, ERR_NONE);
                        cnt = cnt + 2'd1;
                        ph = PH_PLAIN;
                    end
                    else
                    begin
                        hc = byte_in;
                        ph = PH_STRING;
                    end
                end
            endcase

            if (do_plain)
            begin
                if (is_alpha(byte_in))
                begin
                    if (m == MODE_NUMBER)
                    begin
                        res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, KIND_NUMBER, ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                    m = MODE_WORD;
                    res[cnt[0]] = mk(byte_in, 1'b1, 1'b0, KIND_WORD, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
                else if (is_digit(byte_in))
                begin
                    if (m == MODE_WORD)
                    begin
                        res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, KIND_WORD, ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                    m = MODE_NUMBER;
                    res[cnt[0]] = mk(byte_in, 1'b1, 1'b0, KIND_NUMBER, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
                else if (byte_in == CH_SPACE || is_punct(byte_in))
                begin
                    if (byte_in == CH_SLASH)
                    begin
                        ph = PH_SLASH;
                    end
                    else
                    begin
                        if (m != MODE_NONE)
                        begin
                            res[cnt[0]] = mk(8'd0, 1'b0, 1'b1, m - 2'd1, ERR_NONE);
                            cnt = cnt + 2'd1;
                            m = MODE_NONE;
                        end
                        if (byte_in == CH_QUOTE)
                        begin
                            ph = PH_QUOTE;
                        end
                        else if (byte_in != CH_SPACE)
                        begin
                            res[cnt[0]] = mk(byte_in, 1'b1, 1'b1, KIND_PUNCT, ERR_NONE);
                            cnt = cnt + 2'd1;
                        end
                    end
                end
            end
        end

        step.res_n      = cnt;
        step.res0       = res[0];
        step.res1       = res[1];
        step.phase_next = ph;
        step.mode_next  = m;
        step.held_next  = hc;
    end

endmodule

// File: hdl/swt_fifo.sv
`timescale 1ns / 1ps

module swt_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    wr_n,
    input  swt_pkg::res_t wr0,
    input  swt_pkg::res_t wr1,
    output logic          room_two,
    output logic          rd_valid,
    input  logic          rd_ready,
    output swt_pkg::res_t rd_data
);
    import swt_pkg::*;

    res_t       mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign rd_valid = count_reg != 3'd0;
    assign rd_data  = mem[rd_ptr_reg];
    assign pop      = rd_valid & rd_ready;
    // two free slots cover the largest burst of one input word
    assign room_two = count_reg <= 3'd2;

    assign wr_ptr_next = wr_ptr_reg + wr_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, wr_n} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (wr_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (wr_n == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/script_word_tokenizer.sv
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata = byte_in, s_tlast = end_of_input
// m_*       out  m_tvalid/m_tready  m_tdata = token_char, m_tlast = token_last,
//                                   m_tuser = char_valid, token_kind, error_code
// apb       in   psel/penable       end_is_error at byte address 0
//
// one input word per cycle while s_tready is high; its state update happens in the same cycle it is
// accepted and its zero, one or two result words land in a four-entry queue
// a word that makes two results leaves the queue as two result words, so the
// sustained rate is one input word per cycle while each makes at most one result
// s_tready drops while fewer than two queue entries are free
// reset empties the queue, closes any token and sets end_is_error to 1

module script_word_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_input
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] token_char
    output logic        m_tlast,   // token_last
    output logic [4:0]  m_tuser,   // [0] char_valid, [2:1] token_kind, [4:3] error_code
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swt_pkg::*;

    phase_t     phase_reg;
    logic [1:0] mode_reg;
    logic [7:0] held_reg;
    logic       end_is_error_reg;
    logic       accept;
    logic       cfg_write;
    step_t      step;
    res_t       out_res;
    logic       room_two;

    // configuration port, register index taken from address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_END_IS_ERROR) ? {31'd0, end_is_error_reg} : 32'd0;

    assign s_tready = room_two;
    assign accept   = s_tvalid & s_tready;

    // next state and results of the current word
    swt_step u_step (
        .byte_in      (s_tdata),
        .end_of_input (s_tlast),
        .end_is_error (end_is_error_reg),
        .phase        (phase_reg),
        .mode         (mode_reg),
        .held         (held_reg),
        .step         (step)
    );

    // result queue parts the input side from a stalled output
    swt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_n     (accept ? step.res_n : 2'd0),
        .wr0      (step.res0),
        .wr1      (step.res1),
        .room_two (room_two),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = out_res.token_char;
    assign m_tlast = out_res.token_last;
    assign m_tuser = {out_res.error_code, out_res.token_kind, out_res.char_valid};

    // tokenizer state, advanced once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PLAIN;
            mode_reg         <= MODE_NONE;
            held_reg         <= 8'd0;
            end_is_error_reg <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= step.phase_next;
                mode_reg  <= step.mode_next;
                held_reg  <= step.held_next;
            end
            if (cfg_write && paddr[2] == REG_END_IS_ERROR)
            begin
                end_is_error_reg <= pwdata[0];
            end
        end
    end

endmodule
